>>> design/nrtf_pkg.sv
// Shared types and constants for the netlink route table filter.
package nrtf_pkg;

    localparam logic [15:0] CHUNK_MAX      = 16'd65535;
    localparam int          HOLD_BYTES     = 21;
    localparam int          HOLD_IDX_W     = $clog2(HOLD_BYTES);
    localparam logic [15:0] HDR_BYTES      = 16'd16;
    localparam logic [15:0] TABLE_OFFSET   = 16'd20;
    localparam logic [31:0] ROUTE_MIN_LEN  = 32'd28;
    localparam logic [15:0] ROUTE_ADD_TYPE = 16'd24;
    localparam logic [7:0]  TABLE_UNSPEC   = 8'd0;
    localparam logic [7:0]  TABLE_DEFAULT  = 8'd254;
    localparam logic [7:0]  TABLE_LOCAL    = 8'd255;

    localparam int          QUEUE_DEPTH    = 4;
    localparam int          QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_UNDECIDED,
        MODE_KEEP,
        MODE_DROP
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RELEASE,
        SEQ_SUMMARY
    } seq_state_t;

    typedef struct packed {
        logic [7:0]  data_val;
        logic        summary;
        logic [15:0] kept;
        logic        last;
    } result_t;

endpackage

>>> design/nrtf_front.sv
// Front end: chunk and message parser, header hold buffer and release sequencer.
module nrtf_front
    import nrtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       chunk_start,
    input  logic [15:0] chunk_bytes,
    output logic       push,
    output result_t    push_item,
    input  logic       queue_full
);

    logic        filter_enable_reg;
    logic        chunk_filtering_reg, chunk_filtering_next;
    logic [15:0] chunk_remaining_reg, chunk_remaining_next;
    logic [15:0] msg_position_reg, msg_position_next;
    logic [31:0] msg_length_reg, msg_length_next;
    logic [15:0] msg_span_reg, msg_span_next;
    logic [15:0] msg_type_reg, msg_type_next;
    mode_t       mode_reg, mode_next;
    logic        parse_stopped_reg, parse_stopped_next;
    logic [15:0] kept_count_reg, kept_count_next;
    logic        sum_pend_reg, sum_pend_next;
    logic [HOLD_IDX_W-1:0] rel_idx_reg, rel_idx_next;
    logic [HOLD_IDX_W-1:0] rel_last_reg, rel_last_next;
    seq_state_t  seq_state_reg, seq_state_next;

    logic [7:0]  hold_reg [HOLD_BYTES];

    logic        accept;
    logic        do_emit;
    logic        do_rel;
    logic        do_sum;
    logic [HOLD_IDX_W-1:0] rel_last;
    logic        hold_we;
    logic [HOLD_IDX_W-1:0] hold_addr;

    assign in_ready = (seq_state_reg == SEQ_IDLE) && !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [15:0] rem0;
        logic [15:0] pos0;
        logic [15:0] span0;
        logic [15:0] type0;
        logic [15:0] kept0;
        logic [31:0] len0;
        mode_t       mode0;
        logic        stop0;
        logic        filt0;
        logic [16:0] room;
        logic [16:0] aligned;
        logic [15:0] pos_inc;
        logic        done;

        chunk_filtering_next = chunk_filtering_reg;
        chunk_remaining_next = chunk_remaining_reg;
        msg_position_next    = msg_position_reg;
        msg_length_next      = msg_length_reg;
        msg_span_next        = msg_span_reg;
        msg_type_next        = msg_type_reg;
        mode_next            = mode_reg;
        parse_stopped_next   = parse_stopped_reg;
        kept_count_next      = kept_count_reg;
        do_emit   = 1'b0;
        do_rel    = 1'b0;
        do_sum    = 1'b0;
        rel_last  = '0;
        hold_we   = 1'b0;
        hold_addr = '0;
        room      = '0;
        aligned   = '0;
        pos_inc   = '0;
        done      = 1'b0;

        if (chunk_start)
        begin
            if (chunk_bytes == 16'd0)
                rem0 = 16'd1;
            else if (chunk_bytes > CHUNK_MAX)
                rem0 = CHUNK_MAX;
            else
                rem0 = chunk_bytes;
            kept0 = '0;
            stop0 = 1'b0;
            filt0 = filter_enable_reg;
            pos0  = '0;
            len0  = '0;
            span0 = '0;
            type0 = '0;
            mode0 = MODE_UNDECIDED;
        end
        else
        begin
            rem0  = chunk_remaining_reg;
            kept0 = kept_count_reg;
            stop0 = parse_stopped_reg;
            filt0 = chunk_filtering_reg;
            pos0  = msg_position_reg;
            len0  = msg_length_reg;
            span0 = msg_span_reg;
            type0 = msg_type_reg;
            mode0 = mode_reg;
        end

        if (accept && rem0 != 16'd0)
        begin
            if (filt0)
            begin
                if (!stop0)
                begin
                    if (pos0 == 16'd0)
                    begin
                        len0  = '0;
                        type0 = '0;
                        span0 = '0;
                        mode0 = MODE_UNDECIDED;
                        if (rem0 < HDR_BYTES)
                        begin
                            stop0 = 1'b1;
                            done  = 1'b1;
                        end
                    end
                    if (!done)
                    begin
                        room = {1'b0, rem0} + {1'b0, pos0};
                        if (mode0 == MODE_UNDECIDED)
                        begin
                            if (pos0 < 16'(HOLD_BYTES))
                            begin
                                hold_we   = 1'b1;
                                hold_addr = pos0[HOLD_IDX_W-1:0];
                            end
                            if (pos0 < 16'd4)
                                len0 = len0 | (32'(data_byte) << {pos0[1:0], 3'b000});
                            else if (pos0 < 16'd6)
                                type0 = type0 | (16'(data_byte) << {pos0[0], 3'b000});

                            if (pos0 == HDR_BYTES - 16'd1)
                            begin
                                if (len0 < 32'(HDR_BYTES) || len0 > 32'(room))
                                begin
                                    stop0 = 1'b1;
                                    done  = 1'b1;
                                end
                                else
                                begin
                                    aligned = (len0[16:0] + 17'd3) & ~17'd3;
                                    span0 = (aligned > room) ? room[15:0] : aligned[15:0];
                                    if (!(type0 == ROUTE_ADD_TYPE && len0 >= ROUTE_MIN_LEN))
                                    begin
                                        mode0    = MODE_KEEP;
                                        do_rel   = 1'b1;
                                        rel_last = HOLD_IDX_W'(HDR_BYTES - 16'd1);
                                    end
                                end
                            end
                            else if (pos0 == TABLE_OFFSET)
                            begin
                                if (data_byte == TABLE_UNSPEC || data_byte == TABLE_DEFAULT ||
                                    data_byte == TABLE_LOCAL)
                                begin
                                    mode0    = MODE_KEEP;
                                    do_rel   = 1'b1;
                                    rel_last = HOLD_IDX_W'(TABLE_OFFSET);
                                end
                                else
                                begin
                                    mode0 = MODE_DROP;
                                end
                            end
                        end
                        else if (mode0 == MODE_KEEP)
                        begin
                            do_emit = 1'b1;
                        end

                        if (!done)
                        begin
                            pos_inc = pos0 + 16'd1;
                            if (mode0 != MODE_UNDECIDED && pos_inc >= span0)
                                pos_inc = '0;
                            pos0 = pos_inc;
                        end
                    end
                end
            end
            else
            begin
                do_emit = 1'b1;
            end

            kept0 = kept0 + 16'(do_emit)
                  + (do_rel ? 16'(rel_last) + 16'd1 : 16'd0);
            rem0 = rem0 - 16'd1;
            if (rem0 == 16'd0)
            begin
                do_sum = 1'b1;
                pos0   = '0;
                len0   = '0;
                span0  = '0;
                type0  = '0;
                mode0  = MODE_UNDECIDED;
                stop0  = 1'b0;
            end

            chunk_filtering_next = filt0;
            chunk_remaining_next = rem0;
            msg_position_next    = pos0;
            msg_length_next      = len0;
            msg_span_next        = span0;
            msg_type_next        = type0;
            mode_next            = mode0;
            parse_stopped_next   = stop0;
            kept_count_next      = kept0;
        end
    end

    always_comb
    begin
        seq_state_next = seq_state_reg;
        unique case (seq_state_reg)
            SEQ_IDLE:
            begin
                if (accept && do_rel)
                    seq_state_next = SEQ_RELEASE;
                else if (accept && do_sum && do_emit)
                    seq_state_next = SEQ_SUMMARY;
            end
            SEQ_RELEASE:
            begin
                if (!queue_full && rel_idx_reg == rel_last_reg)
                    seq_state_next = sum_pend_reg ? SEQ_SUMMARY : SEQ_IDLE;
            end
            SEQ_SUMMARY:
            begin
                if (!queue_full)
                    seq_state_next = SEQ_IDLE;
            end
            default:
            begin
                seq_state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push          = 1'b0;
        push_item     = '0;
        sum_pend_next = sum_pend_reg;
        rel_idx_next  = rel_idx_reg;
        rel_last_next = rel_last_reg;
        unique case (seq_state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    sum_pend_next = do_sum;
                    rel_idx_next  = '0;
                    rel_last_next = rel_last;
                    if (do_emit)
                    begin
                        push               = 1'b1;
                        push_item.data_val = data_byte;
                        push_item.last     = !do_sum;
                    end
                    else if (do_sum && !do_rel)
                    begin
                        push              = 1'b1;
                        push_item.summary = 1'b1;
                        push_item.kept    = kept_count_next;
                        push_item.last    = 1'b1;
                    end
                end
            end
            SEQ_RELEASE:
            begin
                if (!queue_full)
                begin
                    push               = 1'b1;
                    push_item.data_val = hold_reg[rel_idx_reg];
                    push_item.last     = (rel_idx_reg == rel_last_reg) && !sum_pend_reg;
                    rel_idx_next       = rel_idx_reg + HOLD_IDX_W'(1);
                end
            end
            SEQ_SUMMARY:
            begin
                if (!queue_full)
                begin
                    push              = 1'b1;
                    push_item.summary = 1'b1;
                    push_item.kept    = kept_count_reg;
                    push_item.last    = 1'b1;
                    sum_pend_next     = 1'b0;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
            hold_reg[hold_addr] <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg   <= 1'b1;
            chunk_filtering_reg <= 1'b0;
            chunk_remaining_reg <= '0;
            msg_position_reg    <= '0;
            msg_length_reg      <= '0;
            msg_span_reg        <= '0;
            msg_type_reg        <= '0;
            mode_reg            <= MODE_UNDECIDED;
            parse_stopped_reg   <= 1'b0;
            kept_count_reg      <= '0;
            sum_pend_reg        <= 1'b0;
            rel_idx_reg         <= '0;
            rel_last_reg        <= '0;
            seq_state_reg       <= SEQ_IDLE;
        end
        else
        begin
            if (cfg_we)
                filter_enable_reg <= cfg_wdata;
            chunk_filtering_reg <= chunk_filtering_next;
            chunk_remaining_reg <= chunk_remaining_next;
            msg_position_reg    <= msg_position_next;
            msg_length_reg      <= msg_length_next;
            msg_span_reg        <= msg_span_next;
            msg_type_reg        <= msg_type_next;
            mode_reg            <= mode_next;
            parse_stopped_reg   <= parse_stopped_next;
            kept_count_reg      <= kept_count_next;
            sum_pend_reg        <= sum_pend_next;
            rel_idx_reg         <= rel_idx_next;
            rel_last_reg        <= rel_last_next;
            seq_state_reg       <= seq_state_next;
        end
    end

endmodule

>>> design/nrtf_queue.sv
// Short result queue between the parser and the output stage.
module nrtf_queue
    import nrtf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_item,
    output logic    full,
    input  logic    pop,
    output result_t pop_item,
    output logic    empty
);

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        if (pop && !empty)
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        if ((push && !full) && !(pop && !empty))
            count_next = count_reg + (QUEUE_PTR_W + 1)'(1);
        else if (!(push && !full) && (pop && !empty))
            count_next = count_reg - (QUEUE_PTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/nrtf_back.sv
// Back end: output register that presents queued results on the master stream.
module nrtf_back
    import nrtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  result_t     queue_item,
    output logic        queue_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    logic    out_valid_reg, out_valid_next;
    result_t out_item_reg;
    logic    load;

    assign load      = !queue_empty && (!out_valid_reg || m_axis_tready);
    assign queue_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= queue_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_item_reg.kept, out_item_reg.data_val};
    assign m_axis_tuser  = out_item_reg.summary;
    assign m_axis_tlast  = out_item_reg.last;

endmodule

>>> design/netlink_route_table_filter.sv
// Top level of the netlink route table filter.
// The block takes one chunk byte per cycle while a byte is dropped or passed straight through,
// and each kept byte is written into the result queue and then into the output register
// before it appears on the result stream. When a message's header is judged kept, the held
// header leaves the hold buffer one byte per cycle, while the result queue is not full, through a
// single release sequencer: 16 bytes for a plain header, or 21 bytes for a route message decided
// at its table byte. The summary of a chunk follows its last byte when a data byte or a released
// header goes out with it. Input stalls while the sequencer is busy or the result queue is full.
module netlink_route_table_filter
    import nrtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // filter_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // data_byte [7:0], chunk_bytes [23:8]
    input  logic        s_axis_tuser,    // chunk_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // out_byte [7:0], kept_bytes [23:8]
    output logic        m_axis_tuser,    // is_summary
    output logic        m_axis_tlast     // last_of_run
);

    logic    q_push;
    result_t q_push_item;
    logic    q_full;
    logic    q_pop;
    result_t q_pop_item;
    logic    q_empty;

    nrtf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .data_byte   (s_axis_tdata[7:0]),
        .chunk_start (s_axis_tuser),
        .chunk_bytes (s_axis_tdata[23:8]),
        .push        (q_push),
        .push_item   (q_push_item),
        .queue_full  (q_full)
    );

    nrtf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    nrtf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (q_empty),
        .queue_item    (q_pop_item),
        .queue_pop     (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> design/nrtf_checker.sv
// Port-level checks on the filter's result stream, bound to the top level.
module nrtf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("Stalled result item changed");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("Summary item not marked as last of run");

    a_summary_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("Summary item carries a data byte");

    a_data_kept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("Data item carries a kept count");

endmodule

bind netlink_route_table_filter nrtf_checker u_checker (.*);

>>> dv/netlink_route_table_filter_tb.sv
// Self-checking testbench for the netlink route table filter, with a built-in predictor.
`timescale 1ns / 1ps

module netlink_route_table_filter_tb
    import nrtf_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_STALL    = 300;

    typedef enum int {
        MSG_PLAIN,
        MSG_ROUTE,
        MSG_BAD
    } msg_kind_t;

    typedef struct {
        logic [7:0]  data;
        logic        start;
        logic [15:0] nbytes;
    } stim_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    stim_item_t  pending_items[$];
    stim_item_t  tx_item;
    logic [7:0]  chunk_buf[$];
    int          stim_count = 0;
    int          tx_idle_pct = 24;
    int          rx_idle_pct = 74;
    int          stalls_requested = 0;
    int          stalls_served = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          errors = 0;

    // Predictor state, mirroring the block's own registers.
    logic [7:0]  hdr_hold [HOLD_BYTES];
    logic [15:0] msg_pos = '0;
    logic [31:0] msg_len = '0;
    logic [15:0] msg_span = '0;
    logic [15:0] msg_type = '0;
    logic [15:0] chunk_left = '0;
    logic [15:0] kept_total = '0;
    mode_t       msg_mode = MODE_UNDECIDED;
    logic        parse_halted = 1'b0;
    logic        chunk_filtering = 1'b0;
    logic        filter_on = 1'b1;

    result_t     byte_results[$];
    result_t     expected_results[$];
    result_t     want;

    netlink_route_table_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void start_message();
        msg_pos  = '0;
        msg_len  = '0;
        msg_span = '0;
        msg_type = '0;
        msg_mode = MODE_UNDECIDED;
    endfunction

    function automatic void keep_byte(input logic [7:0] b);
        result_t r;
        r.data_val = b;
        r.summary  = 1'b0;
        r.kept     = '0;
        r.last     = 1'b0;
        byte_results.push_back(r);
        kept_total = kept_total + 16'd1;
    endfunction

    function automatic void release_hold(input int n);
        for (int i = 0; i < n; i++)
        begin
            keep_byte(hdr_hold[i]);
        end
    endfunction

    function automatic void filter_byte(input logic [7:0] b);
        logic [16:0] room;
        logic [32:0] rounded;
        room = 17'(chunk_left) + 17'(msg_pos);
        if (parse_halted)
            return;
        if (msg_pos == 0)
        begin
            start_message();
            if (chunk_left < HDR_BYTES)
            begin
                parse_halted = 1'b1;
                return;
            end
        end
        if (msg_mode == MODE_UNDECIDED)
        begin
            if (msg_pos < HOLD_BYTES)
                hdr_hold[msg_pos] = b;
            if (msg_pos < 4)
                msg_len = msg_len | (32'(b) << (8 * msg_pos));
            else if (msg_pos < 6)
                msg_type = msg_type | (16'(b) << (8 * (msg_pos - 4)));
            if (msg_pos == HDR_BYTES - 16'd1)
            begin
                if (msg_len < 32'(HDR_BYTES) || msg_len > 32'(room))
                begin
                    parse_halted = 1'b1;
                    return;
                end
                rounded  = (33'(msg_len) + 33'd3) & ~33'd3;
                msg_span = (rounded > 33'(room)) ? room[15:0] : rounded[15:0];
                if (!(msg_type == ROUTE_ADD_TYPE && msg_len >= ROUTE_MIN_LEN))
                begin
                    msg_mode = MODE_KEEP;
                    release_hold(HDR_BYTES);
                end
            end
            else if (msg_pos == TABLE_OFFSET)
            begin
                if (b == TABLE_UNSPEC || b == TABLE_DEFAULT || b == TABLE_LOCAL)
                begin
                    msg_mode = MODE_KEEP;
                    release_hold(TABLE_OFFSET + 1);
                end
                else
                begin
                    msg_mode = MODE_DROP;
                end
            end
        end
        else if (msg_mode == MODE_KEEP)
        begin
            keep_byte(b);
        end
        msg_pos = msg_pos + 16'd1;
        if (msg_mode != MODE_UNDECIDED && msg_pos >= msg_span)
            msg_pos = '0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic start,
                                         input logic [15:0] nbytes);
        result_t closing;
        byte_results.delete();
        if (start)
        begin
            chunk_left      = (nbytes == 0) ? 16'd1 : nbytes;
            kept_total      = '0;
            parse_halted    = 1'b0;
            chunk_filtering = filter_on;
            start_message();
        end
        if (chunk_left == 0)
            return;
        if (chunk_filtering)
            filter_byte(b);
        else
            keep_byte(b);
        chunk_left = chunk_left - 16'd1;
        if (chunk_left == 0)
        begin
            closing.data_val = '0;
            closing.summary  = 1'b1;
            closing.kept     = kept_total;
            closing.last     = 1'b0;
            byte_results.push_back(closing);
            start_message();
            parse_halted = 1'b0;
        end
        if (byte_results.size() != 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i])
            expected_results.push_back(byte_results[i]);
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic start, input logic [15:0] nbytes);
        stim_item_t it;
        it.data   = b;
        it.start  = start;
        it.nbytes = nbytes;
        pending_items.push_back(it);
    endtask

    task automatic add_message(input msg_kind_t kind);
        int          len;
        int          span;
        int          pick;
        logic [15:0] typ;
        logic [7:0]  tbl;
        logic [31:0] len_field;
        logic [7:0]  b;
        typ = 16'($urandom);
        tbl = 8'($urandom);
        case (kind)
            MSG_ROUTE:
            begin
                len  = $urandom_range(28, 40);
                typ  = ROUTE_ADD_TYPE;
                pick = $urandom_range(3);
                if (pick == 0)
                    tbl = TABLE_UNSPEC;
                else if (pick == 1)
                    tbl = TABLE_DEFAULT;
                else if (pick == 2)
                    tbl = TABLE_LOCAL;
            end
            MSG_BAD:
            begin
                len = HDR_BYTES;
            end
            default:
            begin
                len = $urandom_range(16, 34);
                if (typ == ROUTE_ADD_TYPE && len >= ROUTE_MIN_LEN)
                    typ = ROUTE_ADD_TYPE + 16'd1;
                if ($urandom_range(3) == 0)
                begin
                    typ = ROUTE_ADD_TYPE;
                    len = $urandom_range(16, 27);
                end
            end
        endcase
        if (kind == MSG_BAD)
        begin
            len_field = $urandom_range(1) ? 32'($urandom_range(0, 15)) : $urandom;
            span      = HDR_BYTES;
        end
        else
        begin
            len_field = 32'(len);
            span      = (len + 3) & ~3;
        end
        for (int i = 0; i < span; i++)
        begin
            if (i < 4)
                b = len_field[8 * i +: 8];
            else if (i < 6)
                b = typ[8 * (i - 4) +: 8];
            else if (i == TABLE_OFFSET && kind == MSG_ROUTE)
                b = tbl;
            else
                b = 8'($urandom);
            chunk_buf.push_back(b);
        end
    endtask

    task automatic send_buffer(input int declared, input int cut);
        for (int i = 0; i < cut; i++)
        begin
            queue_byte(chunk_buf[i], i == 0, (i == 0) ? 16'(declared) : 16'($urandom));
        end
        stim_count += cut;
    endtask

    task automatic send_chunk();
        int nmsg;
        int r;
        int declared;
        int cut;
        chunk_buf.delete();
        nmsg = $urandom_range(1, 3);
        repeat (nmsg)
        begin
            r = $urandom_range(99);
            if (r < 40)
                add_message(MSG_PLAIN);
            else if (r < 85)
                add_message(MSG_ROUTE);
            else
                add_message(MSG_BAD);
        end
        if ($urandom_range(9) < 3)
        begin
            repeat ($urandom_range(1, 18))
                chunk_buf.push_back(8'($urandom));
        end
        declared = chunk_buf.size();
        if ($urandom_range(9) < 2)
            declared -= $urandom_range(1, 3);
        cut = declared;
        if ($urandom_range(19) == 0)
            cut = $urandom_range(1, declared);
        send_buffer(declared, cut);
        if (cut == declared && $urandom_range(9) == 0)
            queue_byte(8'($urandom), 1'b0, 16'($urandom));
    endtask

    task automatic send_random(input int target);
        stim_count = 0;
        while (stim_count < target)
            send_chunk();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_filter(input logic value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        filter_on = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sender: a new item is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                tx_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {tx_item.nbytes, tx_item.data};
                s_axis_tuser  <= tx_item.start;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            stalls_served <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stalls_served != stalls_requested)
        begin
            stalls_served <= stalls_served + 1;
            stall_left    <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[23:8]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected item: out_byte %0d kept_bytes %0d is_summary %0d",
                           m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.data_val)
                    begin
                        $error("out_byte expected %0d actual %0d", want.data_val,
                               m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[23:8] !== want.kept)
                    begin
                        $error("kept_bytes expected %0d actual %0d", want.kept,
                               m_axis_tdata[23:8]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.summary)
                    begin
                        $error("is_summary expected %0d actual %0d", want.summary,
                               m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_of_run expected %0d actual %0d", want.last,
                               m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // A stray byte, a zero length, an abandoned maximum-length chunk, then one
        // plain message followed by a remainder too short for a header.
        queue_byte(8'hFF, 1'b0, 16'hFFFF);
        queue_byte(8'h00, 1'b1, 16'h0000);
        queue_byte(8'hA5, 1'b1, 16'hFFFF);
        queue_byte(8'h5A, 1'b0, 16'h0000);
        chunk_buf.delete();
        chunk_buf.push_back(8'd16);
        repeat (3) chunk_buf.push_back(8'h00);
        repeat (2) chunk_buf.push_back(8'hFF);
        repeat (14) chunk_buf.push_back(8'($urandom));
        send_buffer(20, 20);

        send_random(30);
        wait_drained();
        send_random(30);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        write_filter(1'b0);
        tx_idle_pct = 74;
        rx_idle_pct = 24;
        send_random(35);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        write_filter(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stalls_requested++;
        send_random(45);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected items never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
